// ===== src/list_store_mid_insert_tail_delete_assert.svh =====
// Assertion macros for the list store block.
`ifndef LIST_STORE_MID_INSERT_TAIL_DELETE_ASSERT_SVH
`define LIST_STORE_MID_INSERT_TAIL_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LSTORE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lstore: same-cycle check failed");
`define LSTORE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lstore: next-cycle check failed");
`else
`define LSTORE_ASSERT_IMP(lbl, ante, cons)
`define LSTORE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/lstore_pkg.sv =====
// Shared types and constants for the list store block.
`timescale 1ns / 1ps
`default_nettype none
package lstore_pkg;

  localparam int MODE_W = 2;
  localparam int ITEM_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // what the datapath loads into the result register
  typedef enum logic [2:0] {
    OUT_INS_OK,
    OUT_DEL_OK,
    OUT_DUMP,
    OUT_EMPTY,
    OUT_FULL
  } out_kind_t;

  typedef struct packed {
    logic             ld;
    out_kind_t        kind;
    logic [POS_W-1:0] idx;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/lstore_ctrl.sv =====
// Controller: accepts transactions and sequences list dumps.
`timescale 1ns / 1ps
`default_nettype none
module lstore_ctrl
  import lstore_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire dp_stat_t          stat,
  output dp_cmd_t                cmd
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             free;

  assign free      = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && free;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '{ld: 1'b0, kind: OUT_INS_OK, idx: '0, last: 1'b1};
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_mode)
            MODE_INSERT: begin
              cmd.ld   = 1'b1;
              cmd.kind = stat.full ? OUT_FULL : OUT_INS_OK;
            end
            MODE_DELETE: begin
              cmd.ld   = 1'b1;
              cmd.kind = stat.empty ? OUT_EMPTY : OUT_DEL_OK;
            end
            MODE_DUMP: begin
              if (stat.empty) begin
                cmd.ld   = 1'b1;
                cmd.kind = OUT_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                idx_nxt   = '0;
              end
            end
            default: ;  // unused mode: no result
          endcase
        end
      end
      S_DUMP: begin
        if (free) begin
          cmd.ld   = 1'b1;
          cmd.kind = OUT_DUMP;
          cmd.idx  = idx_r;
          cmd.last = ({1'b0, idx_r} + CNT_W'(1)) == stat.count;
          idx_nxt  = idx_r + POS_W'(1);
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/lstore_dp.sv =====
// Datapath: shifting cell chain, element count and result register.
`timescale 1ns / 1ps
`default_nettype none
module lstore_dp
  import lstore_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [ITEM_W-1:0] in_value,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat,
  output logic        [STAT_W-1:0]      out_status,
  output logic signed [ITEM_W-1:0]      out_item,
  output logic        [POS_W-1:0]       out_position,
  output logic                          out_last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ITEM_W-1:0] cell_r [DEPTH];
  logic        [CNT_W-1:0]  count_r;
  logic        [CNT_W-1:0]  mid;
  logic        [CNT_W-1:0]  rd_idx;
  logic signed [ITEM_W-1:0] rd_data;
  logic                     ins, del;
  logic        [STAT_W-1:0] status_r;
  logic signed [ITEM_W-1:0] item_r;
  logic        [POS_W-1:0]  pos_r;
  logic                     last_r;

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r >= CNT_W'(DEPTH));

  assign ins = cmd.ld && (cmd.kind == OUT_INS_OK);
  assign del = cmd.ld && (cmd.kind == OUT_DEL_OK);

  // middle slot floor((n+1)/2)
  assign mid     = (count_r + CNT_W'(1)) >> 1;
  assign rd_idx  = (cmd.kind == OUT_DEL_OK) ? (count_r - CNT_W'(1)) : {1'b0, cmd.idx};
  assign rd_data = cell_r[rd_idx[IW-1:0]];

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ins && (mid == '0)) begin
          cell_r[j] <= in_value;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (ins) begin
          if (CNT_W'(j) == mid) begin
            cell_r[j] <= in_value;
          end else if ((CNT_W'(j) > mid) && (CNT_W'(j) <= count_r)) begin
            cell_r[j] <= cell_r[j-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ins) begin
      count_r <= count_r + CNT_W'(1);
    end else if (del) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      case (cmd.kind)
        OUT_INS_OK: begin
          status_r <= STAT_OK;
          item_r   <= '0;
          pos_r    <= mid[POS_W-1:0];
          last_r   <= 1'b1;
        end
        OUT_DEL_OK: begin
          status_r <= STAT_OK;
          item_r   <= rd_data;
          pos_r    <= rd_idx[POS_W-1:0];
          last_r   <= 1'b1;
        end
        OUT_DUMP: begin
          status_r <= STAT_OK;
          item_r   <= rd_data;
          pos_r    <= cmd.idx;
          last_r   <= cmd.last;
        end
        OUT_EMPTY: begin
          status_r <= STAT_EMPTY;
          item_r   <= '0;
          pos_r    <= '0;
          last_r   <= 1'b1;
        end
        default: begin
          status_r <= STAT_FULL;
          item_r   <= '0;
          pos_r    <= '0;
          last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_status   = status_r;
  assign out_item     = item_r;
  assign out_position = pos_r;
  assign out_last     = last_r;

endmodule
`default_nettype wire

// ===== src/list_store_mid_insert_tail_delete.sv =====
// List store top level: insert at middle, delete at tail, dump in order.
// One transaction is worked at a time. Insert, delete, a rejected insert and
// every empty-list answer give one result, written to an output register;
// an insert shifts the cells above the middle slot in that same cycle.
// A dump spends one step to start, then gives count results, one per
// cycle while out_ready stays high, read from the cell chain through one
// read select. A new input is accepted when the controller is idle and the
// output register is empty or being drained, so back-to-back single-result
// transactions run at one per cycle. Mode 3 is accepted and gives no result.
// Holds up to DEPTH (1 to 64) values.
`timescale 1ns / 1ps
`default_nettype none
`include "list_store_mid_insert_tail_delete_assert.svh"
module list_store_mid_insert_tail_delete
  import lstore_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic        [MODE_W-1:0] in_mode,
  input  wire logic signed [ITEM_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic        [STAT_W-1:0]      out_status,
  output logic signed [ITEM_W-1:0]      out_item,
  output logic        [POS_W-1:0]       out_position,
  output logic                          out_last
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     ins_accept;

  lstore_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  lstore_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .out_status   (out_status),
    .out_item     (out_item),
    .out_position (out_position),
    .out_last     (out_last)
  );

  assign ins_accept = in_valid && in_ready && (in_mode == MODE_INSERT) && !dp_stat.full;

  // a successful insert grows the list by exactly one
  `LSTORE_ASSERT_NXT(a_insert_count, ins_accept, dp_stat.count == $past(dp_stat.count) + CNT_W'(1))
  // error results always close their transaction
  `LSTORE_ASSERT_IMP(a_error_last, (out_valid && (out_status != STAT_OK)), out_last)
  // count never runs past the store
  `LSTORE_ASSERT_IMP(a_count_bound, 1'b1, (dp_stat.count <= CNT_W'(DEPTH)))

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the list store: insert at middle, delete at tail, dump in order.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
  import lstore_pkg::*;
();

  localparam int                LIST_DEPTH  = 32;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;
  localparam int                RAND_SEGS   = 3;
  localparam int                SEG_ITEMS   = 12;
  localparam int                TAIL_CYCLES = 20;
  localparam int                HOLD_CYCLES = 80;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [ITEM_W-1:0] item;
    logic [POS_W-1:0]         position;
    logic                     last;
  } list_resp_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [MODE_W-1:0]        in_mode   = MODE_INSERT;
  logic signed [ITEM_W-1:0] in_value  = '0;
  logic                     out_ready = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [ITEM_W-1:0] out_item;
  logic [POS_W-1:0]         out_position;
  logic                     out_last;

  // shadow copy of the list and the answers still owed
  logic signed [ITEM_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len = 0;
  list_resp_t               resp_q [$];

  int   err_count    = 0;
  int   resp_seen    = 0;
  bit   src_idle_en  = 1'b0;
  bit   sink_idle_en = 1'b0;
  logic out_hold     = 1'b0;
  int   stall_left   = 0;
  event hold_go;

  list_store_mid_insert_tail_delete #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_item    (out_item),
    .out_position(out_position),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  function automatic void log_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void push_resp(logic [STAT_W-1:0] status, logic signed [ITEM_W-1:0] item,
                                    int position, logic last);
    resp_q.push_back('{status: status, item: item, position: POS_W'(position), last: last});
  endfunction

  // Apply one accepted transaction to the shadow list and queue its answers.
  function automatic void list_apply(logic [MODE_W-1:0] mode, logic signed [ITEM_W-1:0] value);
    int slot;
    case (mode)
      MODE_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          push_resp(STAT_FULL, '0, 0, 1'b1);
        end else begin
          slot = (list_len + 1) / 2;
          for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = value;
          list_len++;
          push_resp(STAT_OK, '0, slot, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (list_len == 0) begin
          push_resp(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          list_len--;
          push_resp(STAT_OK, list_mem[list_len], list_len, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (list_len == 0) push_resp(STAT_EMPTY, '0, 0, 1'b1);
        else for (int i = 0; i < list_len; i++)
          push_resp(STAT_OK, list_mem[i], i, i == list_len - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Valid is left high after acceptance so back-to-back transactions need no
  // drop; anything that waits must lower it first.
  task automatic send_op(logic [MODE_W-1:0] mode, logic signed [ITEM_W-1:0] value);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    list_apply(mode, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (resp_q.size() != 0);
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_hold) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always begin
    @(hold_go);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    list_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (resp_q.size() == 0) begin
        log_error($sformatf("unexpected result: status %0d item %0d pos %0d last %0d",
                            out_status, out_item, out_position, out_last));
      end else begin
        want = resp_q.pop_front();
        if (out_status !== want.status || out_item !== want.item ||
            out_position !== want.position || out_last !== want.last)
          log_error($sformatf({"result %0d: expected status %0d item %0d pos %0d last %0d,",
                               " got status %0d item %0d pos %0d last %0d"},
                              resp_seen, want.status, want.item, want.position, want.last,
                              out_status, out_item, out_position, out_last));
      end
      resp_seen++;
    end
  end

  // empty-list answers, field extremes, ignored mode, every operation
  task automatic test_directed();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_op(MODE_DUMP, '0);
    send_op(MODE_DELETE, 32'sh7fff_ffff);
    send_op(MODE_NONE, 32'sh1234_5678);
    send_op(MODE_INSERT, 32'sh7fff_ffff);
    send_op(MODE_INSERT, 32'sh8000_0000);
    send_op(MODE_INSERT, '0);
    send_op(MODE_INSERT, -32'sd1);
    send_op(MODE_INSERT, 32'sh5555_5555);
    send_op(MODE_INSERT, 32'shaaaa_aaaa);
    send_op(MODE_DUMP, -32'sd1);
    send_op(MODE_NONE, -32'sd1);
    send_op(MODE_DUMP, '0);
    send_op(MODE_DELETE, '0);
    send_op(MODE_DELETE, -32'sd1);
    send_op(MODE_DUMP, '0);
    repeat (4) send_op(MODE_DELETE, pick_value());
    send_op(MODE_DELETE, '0);
    send_op(MODE_DUMP, '0);
    wait_drained();
  endtask

  // fill to capacity, rejected inserts, full dump, drain past empty
  task automatic test_full_list();
    while (list_len < LIST_DEPTH) send_op(MODE_INSERT, pick_value());
    send_op(MODE_INSERT, 32'sh7fff_ffff);
    send_op(MODE_INSERT, 32'sh8000_0000);
    send_op(MODE_DUMP, '0);
    send_op(MODE_DELETE, '0);
    send_op(MODE_INSERT, pick_value());
    send_op(MODE_DUMP, '0);
    while (list_len > 0) send_op(MODE_DELETE, pick_value());
    send_op(MODE_DELETE, '0);
    wait_drained();
  endtask

  // receiver blocked for a long stretch while transactions keep coming
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (12) send_op(MODE_INSERT, pick_value());
    -> hold_go;
    send_op(MODE_DUMP, '0);
    repeat (3) send_op(MODE_INSERT, pick_value());
    send_op(MODE_DUMP, '0);
    repeat (2) send_op(MODE_DELETE, '0);
    send_op(MODE_NONE, pick_value());
    send_op(MODE_INSERT, pick_value());
    send_op(MODE_DUMP, '0);
    wait_drained();
  endtask

  // alternating fill and drain segments; the last one runs without idling
  task automatic test_random();
    int sent;
    int ins_pct;
    int r;
    logic [MODE_W-1:0] mode;
    for (int seg = 0; seg < RAND_SEGS; seg++) begin
      ins_pct      = (seg % 2 == 0) ? 80 : 25;
      src_idle_en  = (seg < RAND_SEGS - 1) && ($urandom_range(0, 2) != 0);
      sink_idle_en = (seg < RAND_SEGS - 1) && ($urandom_range(0, 2) != 0);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 4) mode = MODE_NONE;
        else if (r < 14) mode = MODE_DUMP;
        else if ($urandom_range(0, 99) < ins_pct) mode = MODE_INSERT;
        else mode = MODE_DELETE;
        send_op(mode, pick_value());
        if (mode != MODE_NONE) sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (resp_q.size() != 0) log_error($sformatf("%0d results never arrived", resp_q.size()));
    if (err_count == 0) begin
      $display("PASS list_store_mid_insert_tail_delete");
    end else begin
      $display("FAIL list_store_mid_insert_tail_delete");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL list_store_mid_insert_tail_delete");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/lstore_pkg.sv
src/lstore_ctrl.sv
src/lstore_dp.sv
src/list_store_mid_insert_tail_delete.sv
test/tb_top.sv
